@@ rtl/ssd_pkg.sv @@
package ssd_pkg;

    localparam int DIGITS_DEFAULT = 4;
    localparam int REFRESH_MAX    = 4;
    localparam int NUM_SYMBOLS    = 25;
    localparam int MAX_NUMBER     = 9999;
    localparam int CLEAR_BITS     = 32;
    localparam int BITS_PER_DIGIT = 16;
    localparam int CNT_W          = 6;
    localparam int VAL_W          = 14;
    localparam int RECIP_10       = 6554;

    localparam logic [1:0] OP_SET_NUM = 2'd0;
    localparam logic [1:0] OP_SET_SYM = 2'd1;
    localparam logic [1:0] OP_REFRESH = 2'd2;
    localparam logic [1:0] OP_CLEAR   = 2'd3;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [15:0] number;
        logic [1:0]         position;
        logic [4:0]         symbol;
    } t_in_item;

    typedef struct packed {
        logic data_bit;
        logic latch;
        logic last;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_SHIFT
    } t_state;

    typedef struct packed {
        logic load_num;
        logic put_sym;
        logic split_step;
        logic start_shift;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic num_ok;
        logic split_last;
        logic out_free;
        logic bit_last;
    } t_dp_stat;

    function automatic logic [7:0] seg_pattern(input logic [4:0] code);
        logic [7:0] seg;
        case (code)
            5'd0:    seg = 8'hC0;
            5'd1:    seg = 8'hF9;
            5'd2:    seg = 8'hA4;
            5'd3:    seg = 8'hB0;
            5'd4:    seg = 8'h99;
            5'd5:    seg = 8'h92;
            5'd6:    seg = 8'h82;
            5'd7:    seg = 8'hF8;
            5'd8:    seg = 8'h80;
            5'd9:    seg = 8'h90;
            5'd10:   seg = 8'h88;
            5'd11:   seg = 8'h83;
            5'd12:   seg = 8'hC6;
            5'd13:   seg = 8'hA1;
            5'd14:   seg = 8'h86;
            5'd15:   seg = 8'h8E;
            5'd16:   seg = 8'hFF;
            5'd17:   seg = 8'hBF;
            5'd18:   seg = 8'h7F;
            5'd19:   seg = 8'hDE;
            5'd20:   seg = 8'hE7;
            5'd21:   seg = 8'hF3;
            5'd22:   seg = 8'hFC;
            5'd23:   seg = 8'hD2;
            5'd24:   seg = 8'hE4;
            default: seg = 8'hFF;
        endcase
        return seg;
    endfunction

endpackage

@@ rtl/ssd_ctrl.sv @@
module ssd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_opcode,
    input  ssd_pkg::t_dp_stat i_stat,
    output logic             o_in_ready,
    output ssd_pkg::t_dp_cmd o_cmd
);
    import ssd_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign w_accept = i_in_valid && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_opcode)
                        OP_SET_NUM: n_state = i_stat.num_ok ? ST_SPLIT : ST_IDLE;
                        OP_SET_SYM: n_state = ST_IDLE;
                        OP_REFRESH: n_state = ST_SHIFT;
                        OP_CLEAR:   n_state = ST_SHIFT;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SPLIT: begin
                if (i_stat.split_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SHIFT: begin
                if (i_stat.out_free && i_stat.bit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready        = (r_state == ST_IDLE);
        o_cmd.load_num    = w_accept && (i_opcode == OP_SET_NUM) && i_stat.num_ok;
        o_cmd.put_sym     = w_accept && (i_opcode == OP_SET_SYM);
        o_cmd.start_shift = w_accept && ((i_opcode == OP_REFRESH) || (i_opcode == OP_CLEAR));
        o_cmd.split_step  = (r_state == ST_SPLIT);
        o_cmd.emit        = (r_state == ST_SHIFT) && i_stat.out_free;
    end

endmodule

@@ rtl/ssd_dp.sv @@
module ssd_dp #(
    parameter int DIGITS = ssd_pkg::DIGITS_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ssd_pkg::t_in_item  i_in_data,
    input  ssd_pkg::t_dp_cmd   i_cmd,
    input  logic               i_out_ready,
    output ssd_pkg::t_dp_stat  o_stat,
    output logic               o_out_valid,
    output ssd_pkg::t_out_item o_out_data
);
    import ssd_pkg::*;

    localparam int N_REF = (DIGITS < REFRESH_MAX) ? DIGITS : REFRESH_MAX;
    localparam logic [CNT_W-1:0] LAST_REF   = CNT_W'(BITS_PER_DIGIT * N_REF - 1);
    localparam logic [CNT_W-1:0] LAST_CLEAR = CNT_W'(CLEAR_BITS - 1);

    logic [4:0]       r_codes [DIGITS];
    logic [VAL_W-1:0] r_val;
    logic [1:0]       r_step;
    logic [CNT_W-1:0] r_cnt;
    logic             r_clear;
    logic             r_out_valid;
    t_out_item        r_out;

    logic [4:0]       w_codes4 [REFRESH_MAX];
    logic [26:0]      w_prod;
    logic [VAL_W-1:0] w_q;
    logic [3:0]       w_rem;
    logic [1:0]       w_dig;
    logic [7:0]       w_byte;
    logic [2:0]       w_bpos;
    t_out_item        w_bit;

    genvar g;
    generate
        for (g = 0; g < REFRESH_MAX; g++) begin : g_view
            if (g < DIGITS) begin : g_have
                assign w_codes4[g] = r_codes[g];
            end else begin : g_none
                assign w_codes4[g] = '0;
            end
        end
    endgenerate

    assign w_prod = 27'(r_val) * 27'(RECIP_10);
    assign w_q    = VAL_W'(w_prod >> 16);
    assign w_rem  = 4'(r_val - VAL_W'(w_q * VAL_W'(10)));

    assign w_dig  = r_cnt[5:4];
    assign w_bpos = 3'd7 - r_cnt[2:0];
    assign w_byte = r_cnt[3] ? (8'd1 << w_dig) : seg_pattern(w_codes4[w_dig]);

    always_comb begin
        w_bit.data_bit = r_clear ? 1'b0 : w_byte[w_bpos];
        w_bit.latch    = !r_clear && r_cnt[3] && (r_cnt[2:0] == 3'd7);
        w_bit.last     = o_stat.bit_last;
    end

    always_comb begin
        o_stat.num_ok     = !i_in_data.number[15]
                            && ($unsigned(i_in_data.number) <= 16'(MAX_NUMBER));
        o_stat.split_last = (r_step == 2'd3);
        o_stat.out_free   = !r_out_valid || i_out_ready;
        o_stat.bit_last   = r_clear ? (r_cnt == LAST_CLEAR) : (r_cnt == LAST_REF);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < DIGITS; j++) begin
                r_codes[j] <= '0;
            end
        end else begin
            for (int j = 0; j < DIGITS; j++) begin
                if (i_cmd.split_step && (j < REFRESH_MAX) && (int'(r_step) == j)) begin
                    r_codes[j] <= {1'b0, w_rem};
                end else if (i_cmd.put_sym && (int'(i_in_data.position) == j)
                             && (int'(i_in_data.symbol) < NUM_SYMBOLS)) begin
                    r_codes[j] <= i_in_data.symbol;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_num) begin
            r_val  <= VAL_W'($unsigned(i_in_data.number));
            r_step <= 2'd0;
        end else if (i_cmd.split_step) begin
            r_val  <= w_q;
            r_step <= r_step + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_clear <= 1'b0;
        end else if (i_cmd.start_shift) begin
            r_cnt   <= '0;
            r_clear <= (i_in_data.opcode == OP_CLEAR);
        end else if (i_cmd.emit) begin
            r_cnt   <= r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= w_bit;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ rtl/seven_segment_serial_display_driver.sv @@
// Serial driver for a multiplexed seven-segment module behind two chained
// 8-bit shift registers. Each input transfer is a command; each output transfer
// is one bit for the shift clock, with latch marking a register-clock pulse
// after that bit and last marking the end of the run. A set number command
// with an in-range value starts the decimal split, one digit per cycle
// through a reciprocal multiply that divides by ten. Refresh sends 16 *
// min(DIGITS, 4) bits and clear sends 32 bits, one bit per cycle from a
// single bit counter while the output side keeps ready high; the next command
// is taken once the last bit sits in the output register.
module seven_segment_serial_display_driver #(
    parameter int DIGITS = ssd_pkg::DIGITS_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ssd_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ssd_pkg::t_out_item o_out_data
);
    import ssd_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    ssd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_in_data.opcode),
        .i_stat     (w_stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    ssd_dp #(
        .DIGITS (DIGITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .i_out_ready (i_out_ready),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
